>>> rtl/kpc_pkg.sv
// Shared types and constants for the key press classifier.
package kpc_pkg;

   localparam int unsigned CountWidth = 8;
   localparam int unsigned EventWidth = 2;
   localparam int unsigned CsrIndexWidth = 2;
   localparam int unsigned CsrDataWidth = 8;

   localparam logic [CsrIndexWidth-1:0] CSR_ACTIVE_HIGH = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_LONG_TICKS = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_VERY_LONG_TICKS = 2'd2;

   localparam logic [CountWidth-1:0] LONG_TICKS_RESET = 8'd45;
   localparam logic [CountWidth-1:0] VERY_LONG_TICKS_RESET = 8'd95;

   localparam logic [EventWidth-1:0] EV_NONE = 2'd0;
   localparam logic [EventWidth-1:0] EV_CLICK = 2'd1;
   localparam logic [EventWidth-1:0] EV_LONG = 2'd2;
   localparam logic [EventWidth-1:0] EV_VERY_LONG = 2'd3;

   typedef struct packed {
      logic                  active_high;
      logic [CountWidth-1:0] long_ticks;
      logic [CountWidth-1:0] very_long_ticks;
   } cfg_type;

   typedef struct packed {
      logic key_level;
      logic work_mode;
      logic connect_fail;
      logic smartconfig_mode;
      logic ap_mode;
   } item_type;

endpackage

>>> rtl/kpc_csr.sv
// Configuration registers: key polarity and the two hold thresholds.
module kpc_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [kpc_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [kpc_pkg::CsrDataWidth-1:0]     csr_write_data,
   output kpc_pkg::cfg_type                     cfg
);
   import kpc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_ACTIVE_HIGH:     cfg_in.active_high = csr_write_data[0];
            CSR_LONG_TICKS:      cfg_in.long_ticks = csr_write_data[CountWidth-1:0];
            CSR_VERY_LONG_TICKS: cfg_in.very_long_ticks = csr_write_data[CountWidth-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.active_high <= 1'b0;
         cfg_ff.long_ticks <= LONG_TICKS_RESET;
         cfg_ff.very_long_ticks <= VERY_LONG_TICKS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/kpc_fsm.sv
// Press phase and hold counter; classifies each accepted item into an event.
module kpc_fsm (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               item_accept,
   input  kpc_pkg::item_type                  item,
   input  kpc_pkg::cfg_type                   cfg,
   output logic [kpc_pkg::EventWidth-1:0]     key_event
);
   import kpc_pkg::*;

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_DEBOUNCE = 2'd1;
   localparam logic [1:0] PH_HELD = 2'd2;
   localparam logic [1:0] PH_WAIT = 2'd3;

   logic [1:0]            phase_ff;
   logic [1:0]            phase_in;
   logic [CountWidth-1:0] count_ff;
   logic [CountWidth-1:0] count_in;
   logic [CountWidth-1:0] count_inc;
   logic                  pressed;

   assign pressed = (item.key_level == cfg.active_high);
   assign count_inc = count_ff + CountWidth'(1);

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      key_event = EV_NONE;
      unique case (phase_ff)
         PH_IDLE: begin
            if (pressed) phase_in = PH_DEBOUNCE;
         end
         PH_DEBOUNCE: begin
            if (pressed) begin
               count_in = '0;
               phase_in = PH_HELD;
            end else begin
               phase_in = PH_IDLE;
            end
         end
         PH_HELD: begin
            count_in = count_inc;
            if (!pressed) begin
               key_event = EV_CLICK;
               phase_in = PH_IDLE;
            end else if (count_inc >= cfg.very_long_ticks) begin
               if (item.work_mode || item.connect_fail) begin
                  key_event = EV_VERY_LONG;
                  phase_in = PH_WAIT;
               end
            end else if (count_inc >= cfg.long_ticks) begin
               if ((item.smartconfig_mode || item.ap_mode) && !item.connect_fail) begin
                  key_event = EV_LONG;
                  phase_in = PH_WAIT;
               end
            end
         end
         PH_WAIT: begin
            if (!pressed) phase_in = PH_IDLE;
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         count_ff <= '0;
      end else if (item_accept) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

endmodule

>>> rtl/kpc_out_reg.sv
// Result register: holds one event until it is taken.
module kpc_out_reg (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               load,
   input  logic [kpc_pkg::EventWidth-1:0]     event_in,
   input  logic                               rsp_ready,
   output logic                               rsp_valid,
   output logic [kpc_pkg::EventWidth-1:0]     rsp_key_event
);
   import kpc_pkg::*;

   logic                  valid_ff;
   logic                  valid_in;
   logic [EventWidth-1:0] event_ff;

   assign valid_in = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         event_ff <= event_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_key_event = event_ff;

endmodule

>>> rtl/key_press_classifier.sv
// Top level of the key press classifier.
//
//   channel  direction  handshake              payload
//   req_     in         req_valid/req_ready    key level, four mode flags
//   rsp_     out        rsp_valid/rsp_ready    key_event (2 bits)
//   csr_     in         csr_write_enable       csr_index, csr_write_data
//
// One item per cycle while no result waits unread; its event is visible the cycle after acceptance.
// The phase/counter update and the result register load happen in that
// same accepting edge. req_ready drops only while a result waits unread.
// Synchronous reset: idle phase, counter 0, thresholds 45/95, active low.
module key_press_classifier (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_key_level,
   input  logic                               req_work_mode,
   input  logic                               req_connect_fail,
   input  logic                               req_smartconfig_mode,
   input  logic                               req_ap_mode,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [kpc_pkg::EventWidth-1:0]     rsp_key_event,
   input  logic                               csr_write_enable,
   input  logic [kpc_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [kpc_pkg::CsrDataWidth-1:0]   csr_write_data
);
   import kpc_pkg::*;

   cfg_type               cfg;
   item_type              item;
   logic                  item_accept;
   logic [EventWidth-1:0] key_event;

   assign req_ready = !rsp_valid || rsp_ready;
   assign item_accept = req_valid && req_ready;

   assign item.key_level = req_key_level;
   assign item.work_mode = req_work_mode;
   assign item.connect_fail = req_connect_fail;
   assign item.smartconfig_mode = req_smartconfig_mode;
   assign item.ap_mode = req_ap_mode;

   kpc_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   kpc_fsm u_fsm (
      .clock       (clock),
      .reset       (reset),
      .item_accept (item_accept),
      .item        (item),
      .cfg         (cfg),
      .key_event   (key_event)
   );

   kpc_out_reg u_out (
      .clock         (clock),
      .reset         (reset),
      .load          (item_accept),
      .event_in      (key_event),
      .rsp_ready     (rsp_ready),
      .rsp_valid     (rsp_valid),
      .rsp_key_event (rsp_key_event)
   );

endmodule

>>> rtl/kpc_checker.sv
// Port-level checks for the key press classifier, bound to the top level.
module kpc_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  logic [kpc_pkg::EventWidth-1:0]     rsp_key_event
);
   import kpc_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_key_event))
      else $error("result changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_item_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted item produced no result");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("item accepted over an unread result");

   a_result_has_cause: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid || !$past(rsp_valid) || $past(rsp_ready) |->
         !rsp_valid || $past(req_valid && req_ready))
      else $error("result without an accepted item");

endmodule

bind key_press_classifier kpc_checker u_kpc_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_key_event (rsp_key_event)
);

>>> bench/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for key_press_classifier: directed and random key samples vs. a predictor.
module testbench;
   import kpc_pkg::*;

   localparam logic [CsrIndexWidth-1:0] CSR_UNUSED = 2'd3;
   localparam logic [3:0] MODE_NONE = 4'b0000;
   localparam logic [3:0] MODE_WORK = 4'b1000;
   localparam logic [3:0] MODE_FAIL = 4'b0100;
   localparam logic [3:0] MODE_SMART = 4'b0010;
   localparam logic [3:0] MODE_AP = 4'b0001;
   localparam logic [3:0] MODE_ALL = 4'b1111;
   localparam int CycleLimit = 200000;

   typedef enum logic [1:0] {
      PHASE_IDLE,
      PHASE_DEBOUNCE,
      PHASE_HELD,
      PHASE_RELEASE_WAIT
   } press_phase_type;

   class press_event_tracker_type;
      cfg_type cfg;
      press_phase_type phase;
      logic [CountWidth-1:0] hold_count;
      logic [EventWidth-1:0] expected_events[$];
      int mismatches;

      function new();
         cfg = '{1'b0, LONG_TICKS_RESET, VERY_LONG_TICKS_RESET};
         phase = PHASE_IDLE;
         hold_count = '0;
         mismatches = 0;
      endfunction

      function void set_reg(logic [CsrIndexWidth-1:0] index, logic [CsrDataWidth-1:0] value);
         case (index)
            CSR_ACTIVE_HIGH: cfg.active_high = value[0];
            CSR_LONG_TICKS: cfg.long_ticks = value;
            CSR_VERY_LONG_TICKS: cfg.very_long_ticks = value;
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_events.size();
      endfunction

      function void note_sample(item_type s);
         logic pressed;
         logic [EventWidth-1:0] ev;
         pressed = (s.key_level == cfg.active_high);
         ev = EV_NONE;
         case (phase)
            PHASE_IDLE: begin
               if (pressed) phase = PHASE_DEBOUNCE;
            end
            PHASE_DEBOUNCE: begin
               if (pressed) begin
                  hold_count = '0;
                  phase = PHASE_HELD;
               end else begin
                  phase = PHASE_IDLE;
               end
            end
            PHASE_HELD: begin
               hold_count = hold_count + 1'b1;
               if (!pressed) begin
                  ev = EV_CLICK;
                  phase = PHASE_IDLE;
               end else if (hold_count >= cfg.very_long_ticks) begin
                  if (s.work_mode || s.connect_fail) begin
                     ev = EV_VERY_LONG;
                     phase = PHASE_RELEASE_WAIT;
                  end
               end else if (hold_count >= cfg.long_ticks) begin
                  if ((s.smartconfig_mode || s.ap_mode) && !s.connect_fail) begin
                     ev = EV_LONG;
                     phase = PHASE_RELEASE_WAIT;
                  end
               end
            end
            default: begin
               if (!pressed) phase = PHASE_IDLE;
            end
         endcase
         expected_events.push_back(ev);
      endfunction

      function void check_event(logic [EventWidth-1:0] got);
         logic [EventWidth-1:0] want;
         if (expected_events.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("key_event %0d arrived with none expected", got);
         end else begin
            want = expected_events.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("key_event mismatch: expected %0d, got %0d", want, got);
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic req_key_level;
   logic req_work_mode;
   logic req_connect_fail;
   logic req_smartconfig_mode;
   logic req_ap_mode;
   logic rsp_valid;
   logic rsp_ready;
   logic [EventWidth-1:0] rsp_key_event;
   logic csr_write_enable;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0] csr_write_data;

   press_event_tracker_type tracker;
   bit calm = 1'b0;
   bit clean = 1'b0;
   int hold_off = 0;
   int samples_sent = 0;
   int cycle_count = 0;

   key_press_classifier dut (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("** key_press_classifier: FAILED **");
         $finish;
      end
   end

   function automatic item_type key_sample(input logic key, input logic [3:0] modes);
      return {key, modes};
   endfunction

   task automatic send_sample(input item_type s);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      {req_key_level, req_work_mode, req_connect_fail, req_smartconfig_mode, req_ap_mode} <= s;
      do @(posedge clock); while (!req_ready);
      tracker.note_sample(s);
      samples_sent++;
   endtask

   task automatic send_tick(input bit pressed, input logic [3:0] modes);
      item_type s;
      s = key_sample(pressed ? tracker.cfg.active_high : ~tracker.cfg.active_high, modes);
      if (!clean && $urandom_range(0, 9) == 0) s = item_type'(5'($urandom_range(0, 31)));
      send_sample(s);
   endtask

   // idle lead-in, a hold of the given length (debounce tick included), then release
   task automatic press(input int hold, input int quiet);
      logic [3:0] modes;
      modes = 4'($urandom_range(0, 15));
      repeat ($urandom_range(0, 3)) send_tick(1'b0, 4'($urandom));
      for (int i = 0; i < hold; i++) begin
         if ($urandom_range(0, 3) == 0) modes = 4'($urandom);
         send_tick(1'b1, i < quiet ? MODE_NONE : modes);
      end
      repeat ($urandom_range(1, 3)) send_tick(1'b0, modes);
   endtask

   task automatic run_presses(input int items, input int max_hold);
      int target;
      target = samples_sent + items;
      while (samples_sent < target) press($urandom_range(0, max_hold), 0);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (tracker.pending() > 0);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CsrIndexWidth-1:0] index,
                            input logic [CsrDataWidth-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= value;
      @(posedge clock);
      tracker.set_reg(index, value);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic polarity, input logic [7:0] long_at,
                            input logic [7:0] very_long_at);
      write_reg(CSR_ACTIVE_HIGH, {7'd0, polarity});
      write_reg(CSR_LONG_TICKS, long_at);
      write_reg(CSR_VERY_LONG_TICKS, very_long_at);
   endtask

   initial begin : result_side
      int stall;
      bit held_off;
      held_off = 1'b0;
      rsp_ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off > 0 && !held_off) begin
            stall = hold_off;
            held_off = 1'b1;
         end else begin
            stall = calm ? 0 : $urandom_range(0, 9);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         tracker.check_event(rsp_key_event);
      end
   end

   initial begin : stimulus
      tracker = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_key_level = 1'b0;
      req_work_mode = 1'b0;
      req_connect_fail = 1'b0;
      req_smartconfig_mode = 1'b0;
      req_ap_mode = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = CSR_ACTIVE_HIGH;
      csr_write_data = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: active low, long at 2, very long at 4
      write_reg(CSR_LONG_TICKS, 8'd2);
      write_reg(CSR_VERY_LONG_TICKS, 8'd4);
      send_sample(key_sample(1'b1, MODE_ALL));
      send_sample(key_sample(1'b0, MODE_NONE));
      send_sample(key_sample(1'b1, MODE_NONE));
      send_sample(key_sample(1'b0, MODE_NONE));
      send_sample(key_sample(1'b0, MODE_NONE));
      send_sample(key_sample(1'b1, MODE_NONE));
      repeat (5) send_sample(key_sample(1'b0, MODE_SMART));
      send_sample(key_sample(1'b1, MODE_NONE));
      repeat (6) send_sample(key_sample(1'b0, MODE_FAIL | MODE_SMART));
      send_sample(key_sample(1'b1, MODE_AP));
      // polarity flip while held turns the same level into a release
      repeat (3) send_sample(key_sample(1'b0, MODE_WORK));
      settle();
      write_reg(CSR_ACTIVE_HIGH, 8'd1);
      send_sample(key_sample(1'b0, MODE_NONE));
      settle();
      write_reg(CSR_UNUSED, 8'hFF);

      // reset thresholds, receiver holds off to back up the input
      configure(1'b0, LONG_TICKS_RESET, VERY_LONG_TICKS_RESET);
      hold_off = 80;
      run_presses(100, 110);
      settle();

      calm = 1'b1;
      configure(1'b1, 8'd3, 8'd8);
      run_presses(80, 14);
      settle();
      calm = 1'b0;

      configure(1'b1, 8'd0, 8'd255);
      run_presses(60, 10);
      settle();

      // long threshold above very long
      configure(1'b0, 8'd20, 8'd5);
      run_presses(60, 30);
      settle();

      configure(1'b1, 8'd255, 8'd0);
      run_presses(50, 8);
      settle();

      // hold past 256 ticks with no mode flags so the counter wraps
      configure(1'b0, 8'd2, 8'd4);
      clean = 1'b1;
      press(270, 258);
      clean = 1'b0;
      run_presses(30, 10);
      settle();
      repeat (4) @(posedge clock);

      if (tracker.mismatches == 0 && tracker.pending() == 0) begin
         $display("** key_press_classifier: PASSED **");
      end else begin
         $display("** key_press_classifier: FAILED **");
      end
      $finish;
   end

endmodule
